// File: rtl/ile_pkg.sv
package ile_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_HEAD   = 3'd1;
  localparam logic [2:0] OP_TAIL   = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] MISSING_VALUE = {DATA_W{1'b1}};

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

// File: rtl/ile_cell.sv
module ile_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                           clk,
  input  ile_pkg::cell_cmd_t             cmd,
  input  logic [PW-1:0]                  pos,
  input  logic [ile_pkg::DATA_W-1:0]     ins_value,
  input  logic [ile_pkg::DATA_W-1:0]     left,
  input  logic [ile_pkg::DATA_W-1:0]     right,
  input  logic [PW-1:0]                  rd_pos,
  output logic [ile_pkg::DATA_W-1:0]     data,
  output logic [ile_pkg::DATA_W-1:0]     sel
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  // On insert the cells past the gap take their left neighbor; on delete the
  // removed slot and everything after it take their right neighbor.
  always_ff @(posedge clk) begin
    if (cmd.ins && (pos < MY_POS)) begin
      data <= left;
    end else if (cmd.ins && (pos == MY_POS)) begin
      data <= ins_value;
    end else if (cmd.del && (pos <= MY_POS)) begin
      data <= right;
    end
  end

  assign sel = (rd_pos == MY_POS) ? data : '0;

endmodule

// File: rtl/indexed_list_engine_unit.sv
// Ordered list of up to CAPACITY signed 32-bit values kept in a row of cells,
// one entry per cell. Every command (read, insert at head, append, insert at
// index, delete at index) is accepted whenever start is high; busy stays low, so a new
// command may follow every cycle. Inserts and deletes shift the cells in the
// cycle the command is taken. The result appears on done after the accept,
// group-OR and output registers; a registered OR tree gathers the addressed
// cell for a read. Results must be taken when done is high. The entries need
// no clearing after reset; only the length is reset.
module indexed_list_engine_unit #(
  parameter int CAPACITY = 64,
  localparam int PW      = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           operation,
  input  logic [PW-1:0]        position,
  input  logic signed [31:0]   value,
  output logic                 done,
  output logic signed [31:0]   read_value,
  output logic [1:0]           status,
  output logic [PW-1:0]        length
);

  localparam int GROUP  = 32;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;
  localparam logic [PW-1:0] CAP_LEN = PW'(CAPACITY);

  logic [PW-1:0]                    entry_count;
  logic [PW-1:0]                    entry_count_next;
  logic                             accept;
  ile_pkg::cell_cmd_t               cmd;
  logic [PW-1:0]                    shift_pos;
  logic [1:0]                       st_now;
  logic                             rd_now;

  logic [ile_pkg::DATA_W-1:0]       cell_data [CAPACITY];
  logic [ile_pkg::DATA_W-1:0]       cell_sel  [CAPACITY];
  logic [ile_pkg::DATA_W-1:0]       grp_comb  [NGROUP];
  logic [ile_pkg::DATA_W-1:0]       grp       [NGROUP];
  logic [ile_pkg::DATA_W-1:0]       grp_all;

  // Pipeline: stage 1 after accept, stage 2 after the group OR.
  logic                             v1, v2;
  logic                             rd1, rd2;
  logic [PW-1:0]                    pos1;
  logic [1:0]                       st1, st2;
  logic [PW-1:0]                    len1, len2;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cmd       = '0;
    shift_pos = position;
    st_now    = ile_pkg::ST_DONE;
    rd_now    = 1'b0;
    unique case (operation)
      ile_pkg::OP_READ: begin
        if (position < entry_count) begin
          rd_now = 1'b1;
        end else begin
          st_now = ile_pkg::ST_RANGE;
        end
      end
      ile_pkg::OP_HEAD: begin
        shift_pos = '0;
        if (entry_count == CAP_LEN) begin
          st_now = ile_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      ile_pkg::OP_TAIL: begin
        shift_pos = entry_count;
        if (entry_count == CAP_LEN) begin
          st_now = ile_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      ile_pkg::OP_INSERT: begin
        if (position > entry_count) begin
          st_now = ile_pkg::ST_RANGE;
        end else if (entry_count == CAP_LEN) begin
          st_now = ile_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      ile_pkg::OP_DELETE: begin
        if (position < entry_count) begin
          cmd.del = 1'b1;
        end else begin
          st_now = ile_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd    = '0;
      rd_now = 1'b0;
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    if (cmd.ins) begin
      entry_count_next = entry_count + PW'(1);
    end else if (cmd.del) begin
      entry_count_next = entry_count - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ile_pkg::DATA_W-1:0] left_in;
    logic [ile_pkg::DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[i];
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ile_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (shift_pos),
      .ins_value (value),
      .left      (left_in),
      .right     (right_in),
      .rd_pos    (pos1),
      .data      (cell_data[i]),
      .sel       (cell_sel[i])
    );
  end

  // Only the addressed cell drives nonzero bits, so an OR gathers it.
  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    always_comb begin
      grp_comb[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_comb[g] = grp_comb[g] | cell_sel[g * GROUP + k];
        end
      end
    end
    always_ff @(posedge clk) begin
      grp[g] <= grp_comb[g];
    end
  end

  always_comb begin
    grp_all = '0;
    for (int g = 0; g < NGROUP; g++) begin
      grp_all = grp_all | grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    rd1        <= rd_now;
    pos1       <= position;
    st1        <= st_now;
    len1       <= entry_count_next;
    rd2        <= rd1;
    st2        <= st1;
    len2       <= len1;
    read_value <= rd2 ? grp_all : ile_pkg::MISSING_VALUE;
    status     <= st2;
    length     <= len2;
  end

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2) && !$past(rst, 3)) |-> (done == $past(start, 3)))
    else $error("done does not follow the accepted command by three cycles");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CAP_LEN)
    else $error("entry count exceeds capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ile_pkg::ST_FULL)) |-> (length == CAP_LEN))
    else $error("full status reported while the list is not full");

  a_range_value: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ile_pkg::ST_RANGE)) |-> (read_value == ile_pkg::MISSING_VALUE))
    else $error("out of range result carries a value");

endmodule

// File: tb/tb_indexed_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_indexed_list_engine_unit;

  localparam int CAP = 64;
  localparam int PW = $clog2(CAP + 1);
  localparam int RANDOM_COMMANDS = 400;
  localparam int CYCLE_LIMIT = 100000;

  // Operation codes the block treats as no-ops.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_BALANCED} list_trend_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [PW-1:0]      length;
  } list_outcome_t;

  class list_result_board;
    logic signed [31:0] slots [CAP];
    int                 count;
    list_outcome_t      awaited[$];
    int                 errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %0s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    // Mirrors one accepted command on the list and queues its outcome.
    function void note_command(logic [2:0] op, logic [PW-1:0] pos, logic signed [31:0] val);
      list_outcome_t o;
      int at;
      bit full;
      o.read_value = ile_pkg::MISSING_VALUE;
      o.status = ile_pkg::ST_DONE;
      full = (count >= CAP);
      at = -1;
      case (op)
        ile_pkg::OP_READ: begin
          if (pos < count) o.read_value = slots[pos];
          else o.status = ile_pkg::ST_RANGE;
        end
        ile_pkg::OP_HEAD: begin
          if (full) o.status = ile_pkg::ST_FULL;
          else at = 0;
        end
        ile_pkg::OP_TAIL: begin
          if (full) o.status = ile_pkg::ST_FULL;
          else at = count;
        end
        ile_pkg::OP_INSERT: begin
          // An index past the length wins over the full check.
          if (pos > count) o.status = ile_pkg::ST_RANGE;
          else if (full) o.status = ile_pkg::ST_FULL;
          else at = pos;
        end
        ile_pkg::OP_DELETE: begin
          if (pos < count) begin
            for (int i = pos; i < count - 1; i++) slots[i] = slots[i + 1];
            count--;
          end else begin
            o.status = ile_pkg::ST_RANGE;
          end
        end
        default: ;
      endcase
      if (at >= 0) begin
        for (int i = count; i > at; i--) slots[i] = slots[i - 1];
        slots[at] = val;
        count++;
      end
      o.length = count[PW-1:0];
      awaited.push_back(o);
    endfunction

    task check_result(logic signed [31:0] rd, logic [1:0] st, logic [PW-1:0] len);
      list_outcome_t o;
      if (awaited.size() == 0) begin
        report("result beat with nothing outstanding", rd, 0);
      end else begin
        o = awaited.pop_front();
        if (rd !== o.read_value) report("read_value", rd, o.read_value);
        if (st !== o.status) report("status", st, o.status);
        if (len !== o.length) report("length", len, o.length);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] operation = ile_pkg::OP_READ;
  logic [PW-1:0] position = '0;
  logic signed [31:0] value = '0;
  logic busy;
  logic done;
  logic signed [31:0] read_value;
  logic [1:0] status;
  logic [PW-1:0] length;

  list_result_board board;
  int cycles = 0;
  int calm_left = 0;

  indexed_list_engine_unit #(.CAPACITY(CAP)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .position(position),
    .value(value),
    .done(done),
    .read_value(read_value),
    .status(status),
    .length(length)
  );

  always #10 clk = ~clk;

  // The command beat is noted before the result is checked, so the order
  // also holds if a result came out in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_command(operation, position, value);
      if (done) board.check_result(read_value, status, length);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_command(logic [2:0] op, logic [PW-1:0] pos, logic [31:0] val);
    int gap;
    start <= 1'b1;
    operation <= op;
    position <= pos;
    value <= val;
    do @(posedge clk); while (busy);
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(list_trend_t trend);
    int roll;
    int len;
    logic [2:0] op;
    logic [PW-1:0] pos;
    logic [31:0] val;
    len = board.count;
    roll = $urandom_range(0, 99);
    case (trend)
      TREND_GROW:   roll = (roll < 85) ? 0 : (roll < 95) ? 1 : (roll < 98) ? 2 : 3;
      TREND_SHRINK: roll = (roll < 85) ? 2 : (roll < 95) ? 1 : (roll < 98) ? 0 : 3;
      default:      roll = (roll < 32) ? 0 : (roll < 62) ? 1 : (roll < 95) ? 2 : 3;
    endcase
    case (roll)
      0: begin
        case ($urandom_range(0, 2))
          0: op = ile_pkg::OP_HEAD;
          1: op = ile_pkg::OP_TAIL;
          default: op = ile_pkg::OP_INSERT;
        endcase
      end
      1: op = ile_pkg::OP_READ;
      2: op = ile_pkg::OP_DELETE;
      default: begin
        case ($urandom_range(0, 2))
          0: op = OP_SPARE_5;
          1: op = OP_SPARE_6;
          default: op = OP_SPARE_7;
        endcase
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      if (op == ile_pkg::OP_INSERT) pos = PW'($urandom_range(0, len));
      else pos = (len > 0) ? PW'($urandom_range(0, len - 1)) : '0;
    end else if (roll < 90) begin
      pos = PW'(len + $urandom_range(0, 1));
    end else begin
      pos = PW'($urandom_range(0, 2**PW - 1));
    end
    case ($urandom_range(0, 19))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'h0000_0000;
      3: val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    send_command(op, pos, val);
  endtask

  initial begin
    list_trend_t trend;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty list: every indexed access is out of range.
    send_command(ile_pkg::OP_READ, PW'(0), $urandom);
    send_command(ile_pkg::OP_DELETE, PW'(0), $urandom);
    send_command(ile_pkg::OP_DELETE, PW'(2**PW - 1), $urandom);
    send_command(ile_pkg::OP_INSERT, PW'(1), 32'h1111_1111);
    // Insert at the current length appends.
    send_command(ile_pkg::OP_INSERT, PW'(0), 32'h7FFF_FFFF);
    send_command(ile_pkg::OP_HEAD, PW'(0), 32'h8000_0000);
    send_command(ile_pkg::OP_TAIL, PW'(0), 32'hFFFF_FFFF);
    send_command(ile_pkg::OP_TAIL, PW'(0), 32'h0000_0000);
    send_command(ile_pkg::OP_INSERT, PW'(2), 32'h5555_AAAA);
    send_command(ile_pkg::OP_INSERT, PW'(5), 32'h1234_5678);
    send_command(ile_pkg::OP_INSERT, PW'(7), 32'h2222_2222);
    send_command(ile_pkg::OP_READ, PW'(0), $urandom);
    send_command(ile_pkg::OP_READ, PW'(5), $urandom);
    send_command(ile_pkg::OP_READ, PW'(6), $urandom);
    send_command(ile_pkg::OP_READ, PW'(64), $urandom);
    send_command(ile_pkg::OP_READ, PW'(2**PW - 1), $urandom);
    send_command(OP_SPARE_5, PW'(0), $urandom);
    send_command(OP_SPARE_6, PW'(2**PW - 1), $urandom);
    send_command(OP_SPARE_7, PW'(3), $urandom);
    send_command(ile_pkg::OP_DELETE, PW'(5), $urandom);
    send_command(ile_pkg::OP_DELETE, PW'(0), $urandom);
    send_command(ile_pkg::OP_DELETE, PW'(1), $urandom);
    send_command(ile_pkg::OP_DELETE, PW'(3), $urandom);
    send_command(ile_pkg::OP_INSERT, PW'(2**PW - 1), 32'h3333_3333);
    send_command(ile_pkg::OP_HEAD, PW'(2**PW - 1), 32'h0000_0001);

    // Long growth phases drive the list to full so dropped inserts get hit.
    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      if (i < 80) trend = TREND_GROW;
      else if (i < 140) trend = TREND_BALANCED;
      else if (i < 220) trend = TREND_SHRINK;
      else if (i < 300) trend = TREND_GROW;
      else trend = TREND_BALANCED;
      send_random(trend);
    end
    start <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine_unit.sv
tb/tb_indexed_list_engine_unit.sv
